>>> hdl/fkc_pkg.sv
// package for the flat key to coordinates converter: constants, codes and types
`default_nettype none

package fkc_pkg;

    localparam int MAX_DIMS_DEFAULT    = 3;
    localparam int KEY_WIDTH_DEFAULT   = 64;
    localparam int INDEX_WIDTH_DEFAULT = 32;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 64;
    localparam int STRIDE_WIDTH    = 64;
    localparam int DIMS_WIDTH      = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ACTIVE_DIMS   = 3'd0,
        CFG_STRIDE_OUTER  = 3'd1,
        CFG_STRIDE_MIDDLE = 3'd2,
        CFG_STRIDE_INNER  = 3'd3,
        CFG_SIZE_OUTER    = 3'd4,
        CFG_SIZE_MIDDLE   = 3'd5,
        CFG_SIZE_INNER    = 3'd6
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_CHECK,
        S_FINISH
    } state_t;

endpackage

`default_nettype wire

>>> hdl/flat_key_to_coo_coordinates_core.sv
// flat key to coordinates converter: top level with serial restoring divider
//
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  flat_key, key_present, row_end
// out       output     out_valid/out_stall  row_number, coord_outer/middle/inner, out_of_range
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a word with a key passes through each active dimension in turn, worked by the radix-2
// restoring divider that finds one quotient bit a cycle
// a bare row end word is taken without leaving the idle state and gives no result
// one word is worked on at a time; in_stall is high from acceptance until the result is
// loaded into the output register, which frees the input while the result waits
// rst_n clears the control state and sets every configuration register to 1
`default_nettype none

module flat_key_to_coo_coordinates_core #(
    parameter int MAX_DIMS    = fkc_pkg::MAX_DIMS_DEFAULT,
    parameter int KEY_WIDTH   = fkc_pkg::KEY_WIDTH_DEFAULT,
    parameter int INDEX_WIDTH = fkc_pkg::INDEX_WIDTH_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               in_valid,
    output      logic                               in_stall,
    input  wire logic [KEY_WIDTH-1:0]               flat_key,
    input  wire logic                               key_present,
    input  wire logic                               row_end,

    output      logic                               out_valid,
    input  wire logic                               out_stall,
    output      logic [INDEX_WIDTH-1:0]             row_number,
    output      logic [INDEX_WIDTH-1:0]             coord_outer,
    output      logic [INDEX_WIDTH-1:0]             coord_middle,
    output      logic [INDEX_WIDTH-1:0]             coord_inner,
    output      logic                               out_of_range,

    input  wire logic                               cfg_valid,
    output      logic                               cfg_ready,
    input  wire logic [fkc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [fkc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    localparam int DIM_IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CNT_W     = $clog2(KEY_WIDTH);
    localparam int CMP_W     = (KEY_WIDTH + 1 > fkc_pkg::STRIDE_WIDTH) ?
                               KEY_WIDTH + 1 : fkc_pkg::STRIDE_WIDTH;
    localparam int QW        = (KEY_WIDTH > INDEX_WIDTH) ? KEY_WIDTH : INDEX_WIDTH;

    // configuration
    logic [fkc_pkg::DIMS_WIDTH-1:0]   active_dims_reg;
    logic [fkc_pkg::STRIDE_WIDTH-1:0] stride_reg [MAX_DIMS];
    logic [INDEX_WIDTH-1:0]           size_reg   [MAX_DIMS];

    // control
    fkc_pkg::state_t        state_reg, state_next;
    logic [DIM_IDX_W-1:0]   dim_reg, dim_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   err_reg, err_next;
    logic                   end_reg, end_next;
    logic [INDEX_WIDTH-1:0] row_counter_reg, row_counter_next;
    logic                   row_failed_reg, row_failed_next;
    logic                   out_valid_reg, out_valid_next;

    // datapath
    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    logic [KEY_WIDTH-1:0]   rem_reg, rem_next;
    logic [INDEX_WIDTH-1:0] coord_reg  [MAX_DIMS];
    logic [INDEX_WIDTH-1:0] coord_next [MAX_DIMS];
    logic [INDEX_WIDTH-1:0] row_number_reg, row_number_next;
    logic [INDEX_WIDTH-1:0] coord_out_reg  [MAX_DIMS];
    logic [INDEX_WIDTH-1:0] coord_out_next [MAX_DIMS];
    logic                   out_of_range_reg, out_of_range_next;

    logic                            in_accept;
    logic                            out_free;
    logic [fkc_pkg::STRIDE_WIDTH-1:0] cur_stride;
    logic [INDEX_WIDTH-1:0]          cur_size;
    logic [KEY_WIDTH:0]              trial;
    logic [CMP_W-1:0]                trial_ext;
    logic [CMP_W-1:0]                stride_ext;
    logic [CMP_W-1:0]                diff;
    logic                            fits;
    logic [QW-1:0]                   quot_ext;
    logic [QW-1:0]                   size_ext;
    logic [fkc_pkg::DIMS_WIDTH-1:0]  last_dim_wide;
    logic [DIM_IDX_W-1:0]            last_dim;
    logic                            failed_now;

    assign cfg_ready    = 1'b1;
    assign in_stall     = (state_reg != fkc_pkg::S_IDLE);
    assign in_accept    = in_valid && !in_stall;
    assign out_free     = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign row_number   = row_number_reg;
    assign out_of_range = out_of_range_reg;
    assign coord_outer  = coord_out_reg[0];

    generate
        if (MAX_DIMS > 1)
        begin : g_middle
            assign coord_middle = coord_out_reg[1];
        end
        else
        begin : g_no_middle
            assign coord_middle = '0;
        end
        if (MAX_DIMS > 2)
        begin : g_inner
            assign coord_inner = coord_out_reg[2];
        end
        else
        begin : g_no_inner
            assign coord_inner = '0;
        end
    endgenerate

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_dims_reg <= fkc_pkg::DIMS_WIDTH'(1);
            for (int k = 0; k < MAX_DIMS; k++)
            begin
                stride_reg[k] <= fkc_pkg::STRIDE_WIDTH'(1);
                size_reg[k]   <= INDEX_WIDTH'(1);
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == fkc_pkg::CFG_ACTIVE_DIMS)
            begin
                active_dims_reg <= cfg_data[fkc_pkg::DIMS_WIDTH-1:0];
            end
            for (int k = 0; k < MAX_DIMS; k++)
            begin
                if (cfg_index == fkc_pkg::CFG_INDEX_WIDTH'(fkc_pkg::CFG_STRIDE_OUTER + k))
                begin
                    stride_reg[k] <= cfg_data[fkc_pkg::STRIDE_WIDTH-1:0];
                end
                if (cfg_index == fkc_pkg::CFG_INDEX_WIDTH'(fkc_pkg::CFG_SIZE_OUTER + k))
                begin
                    size_reg[k] <= cfg_data[INDEX_WIDTH-1:0];
                end
            end
        end
    end

    // divider step and checks
    assign cur_stride = stride_reg[dim_reg];
    assign cur_size   = size_reg[dim_reg];
    assign trial      = {rem_reg, key_reg[KEY_WIDTH-1]};
    assign trial_ext  = CMP_W'(trial);
    assign stride_ext = CMP_W'(cur_stride);
    assign diff       = trial_ext - stride_ext;
    assign fits       = (trial_ext >= stride_ext);
    assign quot_ext   = QW'(key_reg);
    assign size_ext   = QW'(cur_size);

    // zero means one, anything above the limit saturates
    always_comb
    begin
        if (active_dims_reg == '0)
        begin
            last_dim_wide = '0;
        end
        else if (active_dims_reg > fkc_pkg::DIMS_WIDTH'(MAX_DIMS))
        begin
            last_dim_wide = fkc_pkg::DIMS_WIDTH'(MAX_DIMS - 1);
        end
        else
        begin
            last_dim_wide = active_dims_reg - fkc_pkg::DIMS_WIDTH'(1);
        end
    end
    assign last_dim   = last_dim_wide[DIM_IDX_W-1:0];
    assign failed_now = row_failed_reg || err_reg;

    always_comb
    begin
        state_next        = state_reg;
        dim_next          = dim_reg;
        cnt_next          = cnt_reg;
        err_next          = err_reg;
        end_next          = end_reg;
        row_counter_next  = row_counter_reg;
        row_failed_next   = row_failed_reg;
        out_valid_next    = out_valid_reg && out_stall;
        key_next          = key_reg;
        rem_next          = rem_reg;
        coord_next        = coord_reg;
        row_number_next   = row_number_reg;
        coord_out_next    = coord_out_reg;
        out_of_range_next = out_of_range_reg;

        case (state_reg)
            fkc_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    if (key_present)
                    begin
                        key_next   = flat_key;
                        end_next   = row_end;
                        err_next   = 1'b0;
                        dim_next   = '0;
                        for (int k = 0; k < MAX_DIMS; k++)
                        begin
                            coord_next[k] = '0;
                        end
                        state_next = fkc_pkg::S_START;
                    end
                    else if (row_end)
                    begin
                        if (!row_failed_reg)
                        begin
                            row_counter_next = row_counter_reg + INDEX_WIDTH'(1);
                        end
                        row_failed_next = 1'b0;
                    end
                end
            end
            fkc_pkg::S_START:
            begin
                if (cur_stride == '0)
                begin
                    err_next   = 1'b1;
                    state_next = fkc_pkg::S_FINISH;
                end
                else
                begin
                    rem_next   = '0;
                    cnt_next   = CNT_W'(KEY_WIDTH - 1);
                    state_next = fkc_pkg::S_DIV;
                end
            end
            fkc_pkg::S_DIV:
            begin
                // key shifts out at the top, quotient bits enter at the bottom
                rem_next = fits ? diff[KEY_WIDTH-1:0] : trial[KEY_WIDTH-1:0];
                key_next = {key_reg[KEY_WIDTH-2:0], fits};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = fkc_pkg::S_CHECK;
                end
            end
            fkc_pkg::S_CHECK:
            begin
                if (quot_ext >= size_ext)
                begin
                    err_next   = 1'b1;
                    state_next = fkc_pkg::S_FINISH;
                end
                else
                begin
                    coord_next[dim_reg] = quot_ext[INDEX_WIDTH-1:0];
                    key_next            = rem_reg;
                    if (dim_reg == last_dim)
                    begin
                        state_next = fkc_pkg::S_FINISH;
                    end
                    else
                    begin
                        dim_next   = dim_reg + DIM_IDX_W'(1);
                        state_next = fkc_pkg::S_START;
                    end
                end
            end
            fkc_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    row_number_next   = row_counter_reg;
                    coord_out_next    = coord_reg;
                    out_of_range_next = err_reg;
                    if (end_reg)
                    begin
                        if (!failed_now)
                        begin
                            row_counter_next = row_counter_reg + INDEX_WIDTH'(1);
                        end
                        row_failed_next = 1'b0;
                    end
                    else
                    begin
                        row_failed_next = failed_now;
                    end
                    state_next = fkc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fkc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fkc_pkg::S_IDLE;
            dim_reg         <= '0;
            cnt_reg         <= '0;
            err_reg         <= 1'b0;
            end_reg         <= 1'b0;
            row_counter_reg <= '0;
            row_failed_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            dim_reg         <= dim_next;
            cnt_reg         <= cnt_next;
            err_reg         <= err_next;
            end_reg         <= end_next;
            row_counter_reg <= row_counter_next;
            row_failed_reg  <= row_failed_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg          <= key_next;
        rem_reg          <= rem_next;
        coord_reg        <= coord_next;
        row_number_reg   <= row_number_next;
        coord_out_reg    <= coord_out_next;
        out_of_range_reg <= out_of_range_next;
    end

    // partial remainder always stays below the divisor
    a_rem_below_stride: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fkc_pkg::S_DIV) |-> (CMP_W'(rem_reg) < stride_ext))
        else $error("partial remainder not below stride");

    // a word with a key starts the first dimension
    a_key_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && key_present) |=> (state_reg == fkc_pkg::S_START && dim_reg == '0))
        else $error("accepted key did not start conversion");

    // the row counter only ever steps by one
    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        (row_counter_reg != $past(row_counter_reg)) |->
        (row_counter_reg == $past(row_counter_reg) + INDEX_WIDTH'(1)))
        else $error("row counter jumped");

    // the finishing state loads its result when the output register is free
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fkc_pkg::S_FINISH && out_free) |=> out_valid_reg)
        else $error("finished word not loaded into output register");

endmodule

`default_nettype wire

>>> verif/tb_flat_key_to_coo_coordinates_core.sv
// self-checking testbench for the flat key to coordinates converter
`timescale 1ns / 100ps

module tb_flat_key_to_coo_coordinates_core;

    localparam int WORD_CYCLES  = 3 * (fkc_pkg::KEY_WIDTH_DEFAULT + 2) + 2;
    localparam int QUIET_LIMIT  = 5000;
    localparam int PHASE_WORDS  = 567;

    typedef struct packed {
        logic [31:0] row_number;
        logic [31:0] coord_outer;
        logic [31:0] coord_middle;
        logic [31:0] coord_inner;
        logic        out_of_range;
    } coo_word_t;

    class coo_tracker;
        logic [1:0]  dims_reg;
        logic [63:0] stride [3];
        logic [31:0] extent [3];
        logic [31:0] row_count;
        bit          row_bad;
        coo_word_t   coords_due [$];
        int unsigned failures;

        function new();
            dims_reg  = 2'd1;
            for (int d = 0; d < 3; d++)
            begin
                stride[d] = 64'd1;
                extent[d] = 32'd1;
            end
            row_count = '0;
            row_bad   = 1'b0;
            failures  = 0;
        endfunction

        function void set_reg(fkc_pkg::cfg_index_t idx, logic [63:0] value);
            case (idx)
                fkc_pkg::CFG_ACTIVE_DIMS:   dims_reg  = value[1:0];
                fkc_pkg::CFG_STRIDE_OUTER:  stride[0] = value;
                fkc_pkg::CFG_STRIDE_MIDDLE: stride[1] = value;
                fkc_pkg::CFG_STRIDE_INNER:  stride[2] = value;
                fkc_pkg::CFG_SIZE_OUTER:    extent[0] = value[31:0];
                fkc_pkg::CFG_SIZE_MIDDLE:   extent[1] = value[31:0];
                fkc_pkg::CFG_SIZE_INNER:    extent[2] = value[31:0];
                default:                    ;
            endcase
        endfunction

        // unravels one accepted word and queues the coordinates it must give
        function void note_word(logic [63:0] key, bit present, bit ends);
            coo_word_t   w;
            logic [63:0] rest;
            logic [63:0] q;
            logic [31:0] coord [3];
            bit          bad;
            int          n;
            int          d;
            if (present)
            begin
                n    = (dims_reg == 2'd0) ? 1 : int'(dims_reg);
                rest = key;
                bad  = 1'b0;
                for (d = 0; d < 3; d++)
                    coord[d] = '0;
                for (d = 0; d < n && !bad; d++)
                begin
                    if (stride[d] == 64'd0)
                        bad = 1'b1;
                    else
                    begin
                        q = rest / stride[d];
                        if (q >= {32'd0, extent[d]})
                            bad = 1'b1;
                        else
                        begin
                            coord[d] = q[31:0];
                            rest     = rest % stride[d];
                        end
                    end
                end
                if (bad)
                    row_bad = 1'b1;
                w.row_number   = row_count;
                w.coord_outer  = coord[0];
                w.coord_middle = coord[1];
                w.coord_inner  = coord[2];
                w.out_of_range = bad;
                coords_due.push_back(w);
            end
            if (ends)
            begin
                if (!row_bad)
                    row_count = row_count + 32'd1;
                row_bad = 1'b0;
            end
        endfunction

        function void check_result(coo_word_t got);
            coo_word_t want;
            if (coords_due.size() == 0)
            begin
                $error("result word with nothing expected: row %0d", got.row_number);
                failures++;
                return;
            end
            want = coords_due.pop_front();
            if (got.row_number !== want.row_number)
            begin
                $error("row_number: expected %0d, got %0d", want.row_number, got.row_number);
                failures++;
            end
            if (got.coord_outer !== want.coord_outer)
            begin
                $error("coord_outer: expected %0d, got %0d", want.coord_outer, got.coord_outer);
                failures++;
            end
            if (got.coord_middle !== want.coord_middle)
            begin
                $error("coord_middle: expected %0d, got %0d",
                       want.coord_middle, got.coord_middle);
                failures++;
            end
            if (got.coord_inner !== want.coord_inner)
            begin
                $error("coord_inner: expected %0d, got %0d", want.coord_inner, got.coord_inner);
                failures++;
            end
            if (got.out_of_range !== want.out_of_range)
            begin
                $error("out_of_range: expected %0d, got %0d",
                       want.out_of_range, got.out_of_range);
                failures++;
            end
        endfunction

        function int unsigned pending();
            return coords_due.size();
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid;
    logic                                in_stall;
    logic [63:0]                         flat_key;
    logic                                key_present;
    logic                                row_end;
    logic                                out_valid;
    logic                                out_stall;
    logic [31:0]                         row_number;
    logic [31:0]                         coord_outer;
    logic [31:0]                         coord_middle;
    logic [31:0]                         coord_inner;
    logic                                out_of_range;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [fkc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [fkc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

    coo_tracker  tracker = new();
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned quiet_cycles;
    logic [63:0] cur_stride [3];
    logic [31:0] cur_size [3];

    flat_key_to_coo_coordinates_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .flat_key     (flat_key),
        .key_present  (key_present),
        .row_end      (row_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .row_number   (row_number),
        .coord_outer  (coord_outer),
        .coord_middle (coord_middle),
        .coord_inner  (coord_inner),
        .out_of_range (out_of_range),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result({row_number, coord_outer, coord_middle, coord_inner,
                                  out_of_range});
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
            || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("flat_key_to_coo_coordinates_core regression: fail");
            $finish;
        end
    end

    task automatic send_word(logic [63:0] key, bit present, bit ends);
        int unsigned gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct)
            gap = ($urandom_range(19) == 0) ? $urandom_range(30, 300) : $urandom_range(1, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        flat_key    <= key;
        key_present <= present;
        row_end     <= ends;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_word(key, present, ends);
    endtask

    // hold the input until every expected word is out; extra adds a further wait
    task automatic settle(bit extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        if (extra)
            repeat (WORD_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(fkc_pkg::cfg_index_t idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.set_reg(idx, value);
    endtask

    task automatic set_all(logic [1:0] dims, logic [63:0] s0, logic [63:0] s1,
                           logic [63:0] s2, logic [31:0] z0, logic [31:0] z1,
                           logic [31:0] z2);
        settle(1'b1);
        write_reg(fkc_pkg::CFG_ACTIVE_DIMS, {62'd0, dims});
        write_reg(fkc_pkg::CFG_STRIDE_OUTER, s0);
        write_reg(fkc_pkg::CFG_STRIDE_MIDDLE, s1);
        write_reg(fkc_pkg::CFG_STRIDE_INNER, s2);
        write_reg(fkc_pkg::CFG_SIZE_OUTER, {32'd0, z0});
        write_reg(fkc_pkg::CFG_SIZE_MIDDLE, {32'd0, z1});
        write_reg(fkc_pkg::CFG_SIZE_INNER, {32'd0, z2});
        cfg_valid  <= 1'b0;
        cur_stride[0] = s0;
        cur_stride[1] = s1;
        cur_stride[2] = s2;
        cur_size[0]   = z0;
        cur_size[1]   = z1;
        cur_size[2]   = z2;
    endtask

    function automatic logic [63:0] any_value();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return {$urandom, $urandom};
            default: return 64'($urandom_range(1, 1000));
        endcase
    endfunction

    task automatic random_setting();
        logic [63:0] s [3];
        logic [31:0] z [3];
        logic [1:0]  dims;
        logic [63:0] v;
        if ($urandom_range(4) == 0)
        begin
            dims = 2'($urandom_range(3));
            for (int d = 0; d < 3; d++)
            begin
                s[d] = any_value();
                v    = any_value();
                z[d] = v[31:0];
            end
        end
        else
        begin
            dims = ($urandom_range(15) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
            for (int d = 0; d < 3; d++)
                z[d] = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 16);
            s[2] = 64'($urandom_range(1, 4));
            s[1] = s[2] * z[2];
            s[0] = s[1] * z[1];
        end
        set_all(dims, s[0], s[1], s[2], z[0], z[1], z[2]);
    endtask

    function automatic logic [63:0] shaped_key();
        logic [63:0] k;
        logic [31:0] c;
        case ($urandom_range(19))
            0:       k = '0;
            1:       k = '1;
            2, 3:    k = {$urandom, $urandom};
            default:
            begin
                k = '0;
                for (int d = 0; d < 3; d++)
                begin
                    c = (cur_size[d] == 0) ? 32'd0 : $urandom_range(cur_size[d] - 1);
                    if ($urandom_range(15) == 0)
                        c = cur_size[d];
                    k = k + c * cur_stride[d];
                end
                if (cur_stride[2] > 1)
                    k = k + ({$urandom, $urandom} % cur_stride[2]);
            end
        endcase
        return k;
    endfunction

    initial
    begin
        int unsigned sent;
        bit          present;
        bit          ends;
        in_valid      <= 1'b0;
        flat_key      <= '0;
        key_present   <= 1'b0;
        row_end       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= fkc_pkg::CFG_ACTIVE_DIMS;
        cfg_data      <= '0;
        send_idle_pct = 15;
        recv_idle_pct = 66;
        quiet_cycles  = 0;
        for (int d = 0; d < 3; d++)
        begin
            cur_stride[d] = 64'd1;
            cur_size[d]   = 32'd1;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: one dimension of size one, failed row, a bare row end and an empty word
        send_word(64'd0, 1'b1, 1'b0);
        send_word(64'd1, 1'b1, 1'b1);
        send_word(64'd0, 1'b1, 1'b1);
        send_word(64'd0, 1'b0, 1'b1);
        send_word('1, 1'b0, 1'b0);

        // errors in each dimension, keys after an error
        set_all(2'd3, 64'd100, 64'd10, 64'd1, 32'd10, 32'd5, 32'd3);
        send_word(64'd0, 1'b1, 1'b0);
        send_word(64'd942, 1'b1, 1'b0);
        send_word(64'd1000, 1'b1, 1'b0);
        send_word(64'd170, 1'b1, 1'b0);
        send_word(64'd5, 1'b1, 1'b1);
        send_word(64'd412, 1'b1, 1'b1);
        send_word('1, 1'b1, 1'b1);

        // widest stride and size, zero stride in the middle, unused inner dimension
        set_all(2'd2, '1, 64'd0, 64'd7, '1, 32'd1, 32'd0);
        send_word('1, 1'b1, 1'b0);
        send_word(64'd5, 1'b1, 1'b1);

        // zero dimensions counts as one
        set_all(2'd0, 64'd1, 64'd0, 64'd0, '1, 32'd0, 32'd0);
        send_word(64'd12345, 1'b1, 1'b0);
        send_word('1, 1'b1, 1'b0);
        send_word(64'hFFFF_FFFE, 1'b1, 1'b1);

        // zero stride in the outer dimension
        set_all(2'd3, 64'd0, 64'd1, 64'd1, '1, '1, '1);
        send_word(64'd0, 1'b1, 1'b1);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 66 : 0;
            recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 15 : 0;
            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                random_setting();
                repeat ($urandom_range(30, 90))
                begin
                    if ($urandom_range(79) == 0)
                        settle(1'b0);
                    present = ($urandom_range(9) != 0);
                    ends    = ($urandom_range(4) == 0);
                    send_word(shaped_key(), present, ends);
                    if (present || ends)
                        sent++;
                end
            end
        end

        settle(1'b1);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("flat_key_to_coo_coordinates_core regression: pass");
        else
            $display("flat_key_to_coo_coordinates_core regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
hdl/fkc_pkg.sv
hdl/flat_key_to_coo_coordinates_core.sv
verif/tb_flat_key_to_coo_coordinates_core.sv
